[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge, masked while synchronous reset is asserted.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/adip_pkg.sv]
// ----------------------------------------------------------------------------
// adip_pkg
// Shared constants and types of the ASCII decimal integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package adip_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CHAR_W          = 8;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 8;
  localparam int DIGIT_W         = 4;

  localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;
  localparam logic [CHAR_W-1:0] SKIP_RESET   = 8'h01;
  localparam logic [CHAR_W-1:0] EOL_RESET    = 8'h0A;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CHAR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EOL_CHAR  = 8'd1;

  // classified character, one queue entry
  typedef struct packed {
    logic               timeout;
    logic               skip;
    logic               minus;
    logic               digit;
    logic               eol;
    logic [DIGIT_W-1:0] digit_val;
  } op_t;

endpackage

`default_nettype wire

[rtl/adip_in_if.sv]
// ----------------------------------------------------------------------------
// adip_in_if
// Character channel: one character or one timeout event per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface adip_in_if;

  logic                         valid;
  logic                         ready;
  logic [adip_pkg::CHAR_W-1:0]  char_code;
  logic                         is_timeout;

  modport source (output valid, output char_code, output is_timeout, input ready);
  modport sink   (input valid, input char_code, input is_timeout, output ready);

endinterface

`default_nettype wire

[rtl/adip_out_if.sv]
// ----------------------------------------------------------------------------
// adip_out_if
// Result channel: one parsed number per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface adip_out_if #(
  parameter int VALUE_WIDTH = adip_pkg::VALUE_WIDTH_DEF
);

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] number_value;
  logic                          success;
  logic                          terminator_consumed;

  modport source (output valid, output number_value, output success,
                  output terminator_consumed, input ready);
  modport sink   (input valid, input number_value, input success,
                  input terminator_consumed, output ready);

endinterface

`default_nettype wire

[rtl/adip_cfg_if.sv]
// ----------------------------------------------------------------------------
// adip_cfg_if
// Register write channel: index and data per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface adip_cfg_if;

  logic                             valid;
  logic                             ready;
  logic [adip_pkg::CFG_IDX_W-1:0]   wr_index;
  logic [adip_pkg::CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, output wr_index, output wr_data, input ready);
  modport sink   (input valid, input wr_index, input wr_data, output ready);

endinterface

`default_nettype wire

[rtl/adip_front.sv]
// ----------------------------------------------------------------------------
// adip_front
// Holds the config registers and classifies each incoming character.
// ----------------------------------------------------------------------------
`default_nettype none

module adip_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  adip_in_if.sink            in_chan,
  adip_cfg_if.sink           cfg_chan,
  input  wire logic          q_ready,
  output logic               push,
  output adip_pkg::op_t      op
);

  logic [adip_pkg::CHAR_W-1:0] skip_r, skip_nxt;
  logic [adip_pkg::CHAR_W-1:0] eol_r,  eol_nxt;
  logic [adip_pkg::CHAR_W-1:0] c;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = q_ready;
  assign push           = in_chan.valid & q_ready;

  always_comb begin
    skip_nxt = skip_r;
    eol_nxt  = eol_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.wr_index)
        adip_pkg::CFG_SKIP_CHAR: skip_nxt = cfg_chan.wr_data;
        adip_pkg::CFG_EOL_CHAR:  eol_nxt  = cfg_chan.wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= adip_pkg::SKIP_RESET;
      eol_r  <= adip_pkg::EOL_RESET;
    end else begin
      skip_r <= skip_nxt;
      eol_r  <= eol_nxt;
    end
  end

  // classification; the back end decides what each flag means in context
  always_comb begin
    c            = in_chan.char_code;
    op.timeout   = in_chan.is_timeout;
    op.skip      = (c == skip_r);
    op.minus     = (c == adip_pkg::CH_MINUS);
    op.digit     = (c >= adip_pkg::CH_ZERO) && (c <= adip_pkg::CH_NINE);
    op.eol       = (c == eol_r);
    op.digit_val = c[adip_pkg::DIGIT_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/adip_queue.sv]
// ----------------------------------------------------------------------------
// adip_queue
// Short FIFO of classified characters between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module adip_queue #(
  parameter int DEPTH = adip_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire adip_pkg::op_t din,
  output logic               ready,
  input  wire logic          pop,
  output logic               valid,
  output adip_pkg::op_t      dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  adip_pkg::op_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign ready = (cnt_r != CNT_W'(DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `ASSERT_SYNC(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH), "queue count overflow")
  `ASSERT_SYNC(a_pop_drains, clk, rst_n, (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1), "queue count did not drop on pop")

endmodule

`default_nettype wire

[rtl/adip_back.sv]
// ----------------------------------------------------------------------------
// adip_back
// Number state machine, accumulator and registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module adip_back #(
  parameter int VALUE_WIDTH = adip_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire adip_pkg::op_t op,
  output logic               pop,
  adip_out_if.source         out_chan
);

  logic                   in_num_r, in_num_nxt;
  logic                   neg_r,    neg_nxt;
  logic                   seen_r,   seen_nxt;
  logic [VALUE_WIDTH-1:0] acc_r,    acc_nxt;

  logic                   ovalid_r, ovalid_nxt;
  logic [VALUE_WIDTH-1:0] oval_r,   oval_nxt;
  logic                   osucc_r,  osucc_nxt;
  logic                   oterm_r,  oterm_nxt;

  logic                   emits;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] sval;
  logic [VALUE_WIDTH-1:0] acc10;

  // does the head item end a number (and so need the result register)
  assign emits    = op.timeout | (in_num_r & ~op.digit & ~op.skip);
  assign out_free = ~ovalid_r | out_chan.ready;
  assign pop      = q_valid & (~emits | out_free);

  assign sval  = neg_r ? (~acc_r + 1'b1) : acc_r;
  // acc*10 as shift-add, wraps at VALUE_WIDTH
  assign acc10 = (acc_r << 3) + (acc_r << 1) + VALUE_WIDTH'(op.digit_val);

  always_comb begin
    in_num_nxt = in_num_r;
    neg_nxt    = neg_r;
    seen_nxt   = seen_r;
    acc_nxt    = acc_r;
    ovalid_nxt = ovalid_r & ~out_chan.ready;
    oval_nxt   = oval_r;
    osucc_nxt  = osucc_r;
    oterm_nxt  = oterm_r;

    if (pop) begin
      if (op.timeout) begin
        // searching state holds zero everywhere, so one path covers both
        ovalid_nxt = 1'b1;
        oval_nxt   = sval;
        osucc_nxt  = seen_r;
        oterm_nxt  = 1'b0;
        in_num_nxt = 1'b0;
        neg_nxt    = 1'b0;
        seen_nxt   = 1'b0;
        acc_nxt    = '0;
      end else if (!in_num_r || op.digit || op.skip) begin
        // start or continue a number; skip test wins over minus and digit
        if (op.minus || op.digit || op.skip && in_num_r) begin
          in_num_nxt = 1'b1;
          if (op.skip) begin
          end else if (op.minus) begin
            neg_nxt = 1'b1;
          end else begin
            acc_nxt  = acc10;
            seen_nxt = 1'b1;
          end
        end
      end else begin
        // terminator
        ovalid_nxt = 1'b1;
        oval_nxt   = sval;
        osucc_nxt  = 1'b1;
        oterm_nxt  = op.eol;
        in_num_nxt = ~op.eol & op.minus;
        neg_nxt    = ~op.eol & op.minus;
        seen_nxt   = 1'b0;
        acc_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_num_r <= 1'b0;
      neg_r    <= 1'b0;
      seen_r   <= 1'b0;
      acc_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      in_num_r <= in_num_nxt;
      neg_r    <= neg_nxt;
      seen_r   <= seen_nxt;
      acc_r    <= acc_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oval_r  <= oval_nxt;
    osucc_r <= osucc_nxt;
    oterm_r <= oterm_nxt;
  end

  assign out_chan.valid               = ovalid_r;
  assign out_chan.number_value        = $signed(oval_r);
  assign out_chan.success             = osucc_r;
  assign out_chan.terminator_consumed = oterm_r;

  `ASSERT_SYNC(a_seen_in_num, clk, rst_n, seen_r |-> in_num_r, "digit seen outside a number")
  `ASSERT_SYNC(a_timeout_clears, clk, rst_n, (pop && op.timeout) |=> (!in_num_r && !neg_r && acc_r == '0), "timeout did not clear number state")
  `ASSERT_SYNC(a_emit_shows, clk, rst_n, (pop && emits) |=> ovalid_r, "ending item produced no result")

endmodule

`default_nettype wire

[rtl/ascii_decimal_integer_parser.sv]
// ----------------------------------------------------------------------------
// ascii_decimal_integer_parser
// Streams characters in, signed decimal integers out.
// ----------------------------------------------------------------------------
// Takes one character (or one timeout event) per transaction on in_chan and
// sustains one transaction per clock. While searching, characters are
// dropped until a minus or a digit starts a number; inside a number digits
// accumulate as value*10+digit (wrapping at VALUE_WIDTH bits), the skip
// character is ignored; only a minus that starts a number sets the sign.
// Any other character ends the number and produces one result on out_chan
// with success=1 and terminator_consumed telling whether it was the
// end-of-line character; a terminating minus that is not end-of-line starts
// the next number. A timeout always produces one result, success meaning at
// least one digit was seen. out_chan.valid rises once the ending character
// has passed through the queue entry and then the result register, while
// classification in the front and the shift-add accumulator update in the
// back are combinational.
// While a result waits, only the ending item at the queue head waits with
// it; in_chan.ready drops once the queue holds QUEUE_DEPTH entries.
// No clearing pass after reset. Configuration writes on cfg_chan (index 0:
// skip char, index 1: end-of-line char) are always taken and apply to
// characters accepted afterwards; write only while the parser is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_decimal_integer_parser #(
  parameter int VALUE_WIDTH = adip_pkg::VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = adip_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  adip_in_if.sink    in_chan,
  adip_cfg_if.sink   cfg_chan,
  adip_out_if.source out_chan
);

  // front to queue
  logic          push;
  logic          q_ready;
  adip_pkg::op_t push_op;

  // queue to back
  logic          q_valid;
  logic          pop;
  adip_pkg::op_t head_op;

  // front: config registers, character classify
  adip_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_ready  (q_ready),
    .push     (push),
    .op       (push_op)
  );

  // decouples the input handshake from result backpressure
  adip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_op),
    .ready (q_ready),
    .pop   (pop),
    .valid (q_valid),
    .dout  (head_op)
  );

  // back: number state, accumulator, result register
  adip_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .op       (head_op),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

[sim/tb_ascii_decimal_integer_parser.sv]
// ----------------------------------------------------------------------------
// tb_ascii_decimal_integer_parser
// Self-checking bench for the ASCII decimal integer parser.
// ----------------------------------------------------------------------------
// A directed list of characters runs first. It covers the timeout while
// searching, the most negative value, a minus that ends one number and
// starts the next, a number made only of minus signs, and bytes at the ends
// of the range. After it come six register settings, extremes included, each
// with random well-formed numbers mixed with noise bytes and timeouts. A
// parser model in the bench predicts each unpinned result. Results are
// checked in order, field by field. Both sides idle at random, save in one
// phase; another holds results off a long stretch so the parser backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ascii_decimal_integer_parser;

  localparam int VALUE_WIDTH  = adip_pkg::VALUE_WIDTH_DEF;
  localparam int CHAR_W       = adip_pkg::CHAR_W;
  localparam int IDLE_PCT     = 12;   // chance of an idle cycle, in percent
  localparam int DRAIN_CYCLES = 6;    // margin after the last expected result
  localparam int HOLD_CYCLES  = 150;  // long result-side hold-off
  localparam int PHASE_ITEMS  = 120;  // random items per register setting
  localparam int N_PHASES     = 6;
  localparam int N_DIRECTED   = 25;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] number_value;
    logic                          success;
    logic                          terminator_consumed;
  } number_result_t;

  // one directed row; pinned rows carry a result typed in by hand
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              tmo;
    logic              pinned;
    number_result_t    res;
  } char_row_t;

  localparam number_result_t NO_RES = '{0, 1'b0, 1'b0};

  logic clk;
  logic rst_n;

  adip_in_if                               in_chan();
  adip_cfg_if                              cfg_chan();
  adip_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) out_chan();

  ascii_decimal_integer_parser #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .out_chan (out_chan)
  );

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The slowest correct run ends long before this timeout.
  initial begin
    #2_000_000;
    $display("tb_ascii_decimal_integer_parser failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Parser model: register copies, number state, and the results still owed
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0]      skip_code;
  logic [CHAR_W-1:0]      eol_code;
  logic                   num_open;       // inside a number
  logic                   num_neg;
  logic                   num_has_digit;
  logic [VALUE_WIDTH-1:0] num_acc;

  number_result_t pending_numbers[$];

  int  mismatch_count = 0;
  int  chars_fed      = 0;
  bit  sender_idle_en = 1'b1;
  bit  sink_stall_en  = 1'b1;
  bit  hold_req       = 1'b0;
  logic hold_off      = 1'b0;

  function automatic bit is_digit(logic [CHAR_W-1:0] code);
    return code >= adip_pkg::CH_ZERO && code <= adip_pkg::CH_NINE;
  endfunction

  function automatic void close_number();
    num_open      = 1'b0;
    num_neg       = 1'b0;
    num_has_digit = 1'b0;
    num_acc       = '0;
  endfunction

  // Character that belongs to a number. Skip test comes first, so a skip
  // char equal to minus or a digit is dropped but still opens the number.
  function automatic void take_char(logic [CHAR_W-1:0] code);
    num_open = 1'b1;
    if (code == skip_code) begin
    end else if (code == adip_pkg::CH_MINUS) begin
      num_neg = 1'b1;
    end else if (is_digit(code)) begin
      num_acc       = num_acc * 10 + (code - adip_pkg::CH_ZERO);   // wraps at width
      num_has_digit = 1'b1;
    end
  endfunction

  // Advance the model by one accepted character; returns 1 with res filled
  // when the character ends a number (or is a timeout).
  function automatic bit parse_char(input logic [CHAR_W-1:0] code, input logic tmo,
                                    output number_result_t res);
    logic [VALUE_WIDTH-1:0] value;
    logic                   consumed;
    value = num_neg ? -num_acc : num_acc;
    res   = NO_RES;
    if (tmo) begin
      // while searching everything is clear, so this gives 0 / no success
      res = '{value, num_has_digit, 1'b0};
      close_number();
      return 1'b1;
    end
    if (!num_open) begin
      if (code == adip_pkg::CH_MINUS || is_digit(code))
        take_char(code);
      return 1'b0;
    end
    if (is_digit(code) || code == skip_code) begin
      take_char(code);
      return 1'b0;
    end
    consumed = (code == eol_code);
    res = '{value, 1'b1, consumed};
    close_number();
    // a terminating minus opens the next number, unless it is end-of-line
    if (!consumed && code == adip_pkg::CH_MINUS)
      take_char(code);
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Character channel driver
  // --------------------------------------------------------------------------
  task automatic feed_char(input logic [CHAR_W-1:0] code, input logic tmo,
                           input logic pinned = 1'b0,
                           input number_result_t pinned_res = NO_RES);
    number_result_t predicted;
    bit             has_result;
    while (sender_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.char_code  <= code;
    in_chan.is_timeout <= tmo;
    do @(posedge clk); while (!in_chan.ready);
    // transaction taken at this edge
    chars_fed++;
    has_result = parse_char(code, tmo, predicted);
    if (pinned)
      pending_numbers.push_back(pinned_res);
    else if (has_result)
      pending_numbers.push_back(predicted);
  endtask

  // Well-formed number: optional minus signs, digits with the odd skip char,
  // then a terminator of some kind.
  task automatic feed_number();
    int n_digits;
    if ($urandom_range(3) == 0)
      feed_char(adip_pkg::CH_MINUS, 1'b0);
    if ($urandom_range(9) == 0)
      feed_char(adip_pkg::CH_MINUS, 1'b0);
    // long runs overflow the accumulator
    n_digits = ($urandom_range(4) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 5);
    for (int i = 0; i < n_digits; i++) begin
      if ($urandom_range(9) == 0)
        feed_char(skip_code, 1'b0);
      feed_char(adip_pkg::CH_ZERO + CHAR_W'($urandom_range(9)), 1'b0);
    end
    case ($urandom_range(5))
      0, 1:    feed_char(eol_code, 1'b0);
      2:       feed_char(adip_pkg::CH_MINUS, 1'b0);
      3:       feed_char(CHAR_W'($urandom_range(255)), 1'b1);
      default: feed_char(CHAR_W'($urandom_range(255)), 1'b0);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Register writes; valid is left high so two writes can follow back to
  // back, and the caller drops it afterwards.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [adip_pkg::CFG_IDX_W-1:0] idx,
                           input logic [adip_pkg::CFG_DATA_W-1:0] data);
    cfg_chan.valid    <= 1'b1;
    cfg_chan.wr_index <= idx;
    cfg_chan.wr_data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      adip_pkg::CFG_SKIP_CHAR: skip_code = data;
      adip_pkg::CFG_EOL_CHAR:  eol_code  = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_numbers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus the long hold-off in its own process
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= !hold_off && !(sink_stall_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    number_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_numbers.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending",
                                  out_chan.number_value));
      end else begin
        want = pending_numbers.pop_front();
        if (out_chan.number_value !== want.number_value)
          report_mismatch($sformatf("number_value got %0d want %0d",
                                    out_chan.number_value, want.number_value));
        if (out_chan.success !== want.success)
          report_mismatch($sformatf("success got %b want %b",
                                    out_chan.success, want.success));
        if (out_chan.terminator_consumed !== want.terminator_consumed)
          report_mismatch($sformatf("terminator_consumed got %b want %b",
                                    out_chan.terminator_consumed,
                                    want.terminator_consumed));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed rows, reset register values (skip 0x01, end-of-line 0x0A)
  // --------------------------------------------------------------------------
  char_row_t dir_rows [N_DIRECTED] = '{
    // timeout while searching: zero, no success
    '{8'h00,    1'b1, 1'b1, '{0, 1'b0, 1'b0}},
    // bytes dropped while searching, both ends of the range
    '{"x",      1'b0, 1'b0, NO_RES},
    '{8'hFF,    1'b0, 1'b0, NO_RES},
    '{8'h00,    1'b0, 1'b0, NO_RES},
    // -2147483648 wraps onto itself, ended by end-of-line
    '{adip_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
    '{"2",      1'b0, 1'b0, NO_RES},
    '{"1",      1'b0, 1'b0, NO_RES},
    '{"4",      1'b0, 1'b0, NO_RES},
    '{"7",      1'b0, 1'b0, NO_RES},
    '{"4",      1'b0, 1'b0, NO_RES},
    '{"8",      1'b0, 1'b0, NO_RES},
    '{"3",      1'b0, 1'b0, NO_RES},
    '{"6",      1'b0, 1'b0, NO_RES},
    '{"4",      1'b0, 1'b0, NO_RES},
    '{"8",      1'b0, 1'b0, NO_RES},
    '{adip_pkg::EOL_RESET, 1'b0, 1'b1, '{32'h8000_0000, 1'b1, 1'b1}},
    // minus ends "9" and starts the next number; timeout delivers -7
    '{"9",      1'b0, 1'b0, NO_RES},
    '{adip_pkg::CH_MINUS, 1'b0, 1'b1, '{9, 1'b1, 1'b0}},
    '{"7",      1'b0, 1'b0, NO_RES},
    '{8'hFF,    1'b1, 1'b1, '{-7, 1'b1, 1'b0}},
    // minus only, ended by a character: zero with success
    '{adip_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
    '{",",      1'b0, 1'b1, '{0, 1'b1, 1'b0}},
    // minus ends a minus-only number and opens another; timeout: no digit
    '{adip_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
    '{adip_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
    '{8'h00,    1'b1, 1'b1, '{0, 1'b0, 1'b0}}
  };

  // Register settings per random phase: ordinary, both extremes, skip equal
  // to minus, skip equal to a digit with end-of-line equal to minus, reset.
  logic [CHAR_W-1:0] skip_plan [N_PHASES] = '{",", 8'h00, 8'hFF, adip_pkg::CH_MINUS, "5",
                                              adip_pkg::SKIP_RESET};
  logic [CHAR_W-1:0] eol_plan  [N_PHASES] = '{adip_pkg::EOL_RESET, 8'hFF, 8'h00, ";",
                                              adip_pkg::CH_MINUS, adip_pkg::EOL_RESET};

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_start;
    int noise_count;
    in_chan.valid      = 1'b0;
    in_chan.char_code  = '0;
    in_chan.is_timeout = 1'b0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.wr_index  = '0;
    cfg_chan.wr_data   = '0;
    skip_code          = adip_pkg::SKIP_RESET;
    eol_code           = adip_pkg::EOL_RESET;
    close_number();

    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      feed_char(dir_rows[i].code, dir_rows[i].tmo, dir_rows[i].pinned, dir_rows[i].res);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // parser back to searching and idle before touching the registers
      feed_char(CHAR_W'($urandom_range(255)), 1'b1);
      in_chan.valid <= 1'b0;
      drain();
      write_reg(adip_pkg::CFG_SKIP_CHAR, skip_plan[ph]);
      write_reg(adip_pkg::CFG_EOL_CHAR, eol_plan[ph]);
      cfg_chan.valid <= 1'b0;

      // phase 1 runs flat out on both sides; phase 2 gets the hold-off
      sender_idle_en = (ph != 1);
      sink_stall_en  = (ph != 1);
      if (ph == 2)
        hold_req = 1'b1;

      phase_start = chars_fed;
      noise_count = 0;
      while (chars_fed - phase_start - noise_count < PHASE_ITEMS) begin
        case ($urandom_range(9))
          0, 1: begin
            feed_char(CHAR_W'($urandom_range(255)), 1'b0);
            noise_count++;
          end
          2:       feed_char(CHAR_W'($urandom_range(255)), 1'b1);
          default: feed_number();
        endcase
      end
    end

    feed_char(CHAR_W'($urandom_range(255)), 1'b1);
    in_chan.valid <= 1'b0;
    drain();

    if (mismatch_count == 0) begin
      $display("tb_ascii_decimal_integer_parser passed");
    end else begin
      $display("tb_ascii_decimal_integer_parser failed");
    end
    $finish;
  end

endmodule
